### hw/rtl/adts_deframer_timestamper_assert.svh
// Assertion macros used by the deframer back end RTL.
`ifndef ADTS_DEFRAMER_TIMESTAMPER_ASSERT_SVH
`define ADTS_DEFRAMER_TIMESTAMPER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ADTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ADTS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define ADTS_ASSERT(lbl, prop, msg)
`define ADTS_NEVER(lbl, cond, msg)
`endif
`endif

### hw/rtl/adts_pkg.sv
package adts_pkg;

    localparam int NUM_W  = 59;
    localparam int RATE_W = 17;
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = 2;

    localparam logic [15:0] SYNC_MASK = 16'hfff6;
    localparam logic [15:0] SYNC_WORD = 16'hfff0;
    localparam logic [26:0] FRAME_TICKS = 27'd92160000;
    localparam logic [6:0]  MS_DIVISOR = 7'd90;
    // The reciprocal of 90 scaled by 2^30 and rounded up; exact for 23-bit dividends.
    localparam logic [23:0] MS_RECIP = 24'd11930465;

    typedef enum logic {
        CFG_START_TIME  = 1'b0,
        CFG_TIME_OFFSET = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] len;
        logic        tail;
        logic        apply;
        logic [3:0]  rate_idx;
        logic [1:0]  block_bits;
    } t_evt;

    function automatic logic [RATE_W-1:0] rate_lut(input logic [3:0] idx);
        logic [RATE_W-1:0] r;
        case (idx)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/adts_front.sv
module adts_front import adts_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_stream_end,
    output logic       o_push,
    output t_evt       o_evt
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] OFF_MAX   = {LB{1'b1}};
    localparam logic [LB-1:0] POS_START = LB'(2);
    localparam logic [LB-1:0] POS_LEN_H = LB'(3);
    localparam logic [LB-1:0] POS_LEN_M = LB'(4);
    localparam logic [LB-1:0] POS_LEN_L = LB'(5);
    localparam logic [LB-1:0] POS_BLK   = LB'(6);
    localparam logic [LB-1:0] POS_MIN   = LB'(8);

    logic [15:0]   r_win, n_win;
    logic          r_hunt, n_hunt;
    logic [LB-1:0] r_off, n_off;
    logic [12:0]   r_hlen, n_hlen;
    logic [3:0]    r_idx, n_idx;
    logic [1:0]    r_bits, n_bits;
    logic [15:0]   win_next;
    logic          sync;

    always_comb begin
        n_win  = r_win;
        n_hunt = r_hunt;
        n_off  = r_off;
        n_hlen = r_hlen;
        n_idx  = r_idx;
        n_bits = r_bits;
        o_push = 1'b0;
        o_evt  = '0;
        win_next = {r_win[7:0], i_data_byte};
        sync = (win_next & SYNC_MASK) == SYNC_WORD;
        if (i_take) begin
            n_win = win_next;
            if (r_hunt) begin
                if (sync) begin
                    n_hunt = 1'b0;
                    n_off  = POS_START;
                    n_hlen = '0;
                    n_idx  = '0;
                    n_bits = '0;
                end
            end else if (!i_stream_end && sync && r_off >= POS_MIN
                         && LB'(r_hlen) <= r_off - LB'(1)) begin
                o_push = 1'b1;
                o_evt.len        = 16'(r_off - LB'(1));
                o_evt.tail       = 1'b0;
                o_evt.apply      = 1'b1;
                o_evt.rate_idx   = r_idx;
                o_evt.block_bits = r_bits;
                n_off  = POS_START;
                n_hlen = '0;
                n_idx  = '0;
                n_bits = '0;
            end else begin
                case (r_off)
                    POS_START: n_idx  = i_data_byte[5:2];
                    POS_LEN_H: n_hlen = {i_data_byte[1:0], 11'd0};
                    POS_LEN_M: n_hlen = r_hlen | {2'd0, i_data_byte, 3'd0};
                    POS_LEN_L: n_hlen = r_hlen | {10'd0, i_data_byte[7:5]};
                    POS_BLK:   n_bits = i_data_byte[1:0];
                    default:   ;
                endcase
                if (r_off != OFF_MAX) begin
                    n_off = r_off + LB'(1);
                end
            end
            if (i_stream_end) begin
                if (!n_hunt) begin
                    o_push = 1'b1;
                    o_evt.len        = 16'(n_off);
                    o_evt.tail       = 1'b1;
                    o_evt.apply      = 1'b0;
                    o_evt.rate_idx   = n_idx;
                    o_evt.block_bits = n_bits;
                end
                n_hunt = 1'b1;
                n_win  = '0;
                n_off  = '0;
                n_hlen = '0;
                n_idx  = '0;
                n_bits = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_hunt <= 1'b1;
            r_off  <= '0;
            r_hlen <= '0;
            r_idx  <= '0;
            r_bits <= '0;
        end else begin
            r_win  <= n_win;
            r_hunt <= n_hunt;
            r_off  <= n_off;
            r_hlen <= n_hlen;
            r_idx  <= n_idx;
            r_bits <= n_bits;
        end
    end

endmodule

### hw/rtl/adts_evq.sv
module adts_evq import adts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    input  logic i_pop,
    output t_evt o_evt,
    output logic o_full,
    output logic o_empty
);

    t_evt                 r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [EVQ_PTR_W:0]   r_cnt;
    logic                 do_push, do_pop;

    assign o_full  = r_cnt == (EVQ_PTR_W+1)'(EVQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_evt   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + EVQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + EVQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (EVQ_PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (EVQ_PTR_W+1)'(1);
            end
        end
    end

endmodule

### hw/rtl/adts_div.sv
module adts_div import adts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [RATE_W-1:0] i_den,
    output logic              o_busy,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [RATE_W:0]    r_rem;
    logic [RATE_W-1:0]  r_den;
    logic [NUM_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy, r_done;
    logic [RATE_W:0]    rem_sh;
    logic               ge;

    assign rem_sh = {r_rem[RATE_W-1:0], r_q[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### hw/rtl/adts_back.sv
`include "adts_deframer_timestamper_assert.svh"
module adts_back import adts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_evq_empty,
    input  t_evt        i_evt,
    output logic        o_evq_pop,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [46:0] i_cfg_data,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [15:0] o_frame_bytes,
    output logic [47:0] o_stamp_ticks,
    output logic [41:0] o_stamp_ms,
    output logic [16:0] o_rate_hz,
    output logic [2:0]  o_blocks_in_frame,
    output logic        o_timed,
    output logic        o_flushed_tail
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b0_0000_0001,
        S_HDR    = 9'b0_0000_0010,
        S_EMIT   = 9'b0_0000_0100,
        S_MUL    = 9'b0_0000_1000,
        S_DSTART = 9'b0_0001_0000,
        S_DWAIT  = 9'b0_0010_0000,
        S_MSLOAD = 9'b0_0100_0000,
        S_MSDIV  = 9'b0_1000_0000,
        S_OUT    = 9'b1_0000_0000
    } t_state;

    t_state            r_st;
    t_evt              r_evt;
    logic              r_apply_phase;
    logic [RATE_W-1:0] r_rnew, r_cur;
    logic [31:0]       r_fsc, r_toff;
    logic [2:0]        r_bc;
    logic [47:0]       r_base, r_stamp;
    logic [NUM_W-1:0]  r_prod;
    logic              r_out_valid;
    logic [47:0]       r_msnum;
    logic [6:0]        r_msrem;
    logic [41:0]       r_msq;
    logic [1:0]        r_mscnt;
    logic [RATE_W-1:0] hdr_rate;
    logic              div_start, div_busy, div_done;
    logic [NUM_W-1:0]  div_num, div_quot;
    logic [RATE_W-1:0] div_den;
    logic [47:0]       stamp_mag, elapsed;
    logic [41:0]       ms_mag;
    logic [22:0]       ms_v, ms_diff;
    logic [46:0]       ms_prod;
    logic [15:0]       ms_q;
    logic [6:0]        ms_rem;
    logic              out_load;

    assign hdr_rate  = rate_lut(r_evt.rate_idx);
    assign stamp_mag = r_stamp[47] ? 48'(-r_stamp) : r_stamp;
    assign elapsed   = div_quot[47:0];
    assign ms_mag    = r_msq;
    assign o_evq_pop = (r_st == S_IDLE) && !i_evq_empty;
    assign out_load  = (r_st == S_OUT) && (!r_out_valid || i_pop);
    assign o_empty   = !r_out_valid;

    // The magnitude is divided by 90 one 16-bit digit per cycle, top digit first.
    assign ms_v    = {r_msrem, r_msnum[47:32]};
    assign ms_prod = {23'd0, MS_RECIP} * {24'd0, ms_v};
    assign ms_q    = ms_prod[45:30];
    assign ms_diff = ms_v - ({7'd0, ms_q} * {16'd0, MS_DIVISOR});
    assign ms_rem  = ms_diff[6:0];

    assign div_start = (r_st == S_DSTART);
    assign div_num   = r_prod;
    assign div_den   = r_cur;

    adts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= S_IDLE;
            r_cur         <= '0;
            r_fsc         <= '0;
            r_toff        <= '0;
            r_bc          <= 3'd1;
            r_base        <= '0;
            r_out_valid   <= 1'b0;
            r_apply_phase <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_START_TIME: begin
                        r_base <= {1'b0, i_cfg_data};
                        r_fsc  <= '0;
                    end
                    CFG_TIME_OFFSET: r_toff <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: begin
                    if (!i_evq_empty) begin
                        r_evt <= i_evt;
                        r_st  <= S_HDR;
                    end
                end
                S_HDR: begin
                    r_st <= S_EMIT;
                    if (r_evt.apply && hdr_rate != '0) begin
                        r_bc <= {1'b0, r_evt.block_bits} + 3'd1;
                        if (hdr_rate != r_cur) begin
                            if (r_cur != '0) begin
                                r_rnew        <= hdr_rate;
                                r_apply_phase <= 1'b1;
                                r_st          <= S_MUL;
                            end else begin
                                r_cur <= hdr_rate;
                                r_fsc <= '0;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (r_cur != '0) begin
                        r_apply_phase <= 1'b0;
                        r_st          <= S_MUL;
                    end else begin
                        r_stamp <= r_base;
                        r_st    <= S_MSLOAD;
                    end
                end
                S_MUL: begin
                    r_prod <= NUM_W'(r_fsc) * NUM_W'(FRAME_TICKS);
                    r_st   <= S_DSTART;
                end
                S_DSTART: r_st <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        if (r_apply_phase) begin
                            r_base <= r_base + elapsed;
                            r_fsc  <= '0;
                            r_cur  <= r_rnew;
                            r_st   <= S_EMIT;
                        end else begin
                            r_stamp <= r_base + {{16{r_toff[31]}}, r_toff} + elapsed;
                            r_st    <= S_MSLOAD;
                        end
                    end
                end
                S_MSLOAD: begin
                    r_msnum <= stamp_mag;
                    r_msrem <= '0;
                    r_mscnt <= '0;
                    r_st    <= S_MSDIV;
                end
                S_MSDIV: begin
                    r_msnum <= {r_msnum[31:0], 16'd0};
                    r_msrem <= ms_rem;
                    r_msq   <= {r_msq[25:0], ms_q};
                    r_mscnt <= r_mscnt + 2'd1;
                    if (r_mscnt == 2'd2) begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        o_frame_bytes     <= r_evt.len;
                        o_stamp_ticks     <= r_stamp;
                        o_stamp_ms        <= r_stamp[47] ? 42'(-ms_mag) : ms_mag;
                        o_rate_hz         <= r_cur;
                        o_blocks_in_frame <= r_bc;
                        o_timed           <= r_cur != '0;
                        o_flushed_tail    <= r_evt.tail;
                        r_fsc             <= r_fsc + 32'(r_bc);
                        r_st              <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `ADTS_NEVER(a_div_overlap, div_start && div_busy, "Divider started while busy.")
    `ADTS_NEVER(a_bc_range, r_bc == 3'd0 || r_bc > 3'd4, "Block count out of range.")
    `ADTS_NEVER(a_wait_idle, (r_st == S_DWAIT) && !div_busy && !div_done, "Waiting on an idle divider.")

endmodule

### hw/rtl/adts_deframer_timestamper.sv
// Channel   Handshake           Beat
// input     i_push / o_full     i_data_byte, i_stream_end
// result    o_empty / i_pop     o_frame_bytes .. o_flushed_tail
// config    i_cfg_valid / ready i_cfg_index, i_cfg_data
// Bytes are taken one per cycle while the four-entry frame queue has room.
// The back end divides by the rate once for a timed frame and twice for one that changes
// a known rate; a frame without a known rate skips the division.
// Reset is synchronous and active low; it clears the sequencing and time-base state.
// A stalled reader holds the output register and the back end; the queue then fills
// and o_full stalls the input.
module adts_deframer_timestamper import adts_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_frame_bytes,
    output logic [47:0] o_stamp_ticks,
    output logic [41:0] o_stamp_ms,
    output logic [16:0] o_rate_hz,
    output logic [2:0]  o_blocks_in_frame,
    output logic        o_timed,
    output logic        o_flushed_tail,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [46:0] i_cfg_data
);

    logic f_push, q_empty, q_pop;
    t_evt f_evt, q_evt;

    assign o_cfg_ready = 1'b1;

    adts_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (i_push && !o_full),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_push       (f_push),
        .o_evt        (f_evt)
    );

    adts_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_evt   (f_evt),
        .i_pop   (q_pop),
        .o_evt   (q_evt),
        .o_full  (o_full),
        .o_empty (q_empty)
    );

    adts_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_evq_empty       (q_empty),
        .i_evt             (q_evt),
        .o_evq_pop         (q_pop),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_frame_bytes     (o_frame_bytes),
        .o_stamp_ticks     (o_stamp_ticks),
        .o_stamp_ms        (o_stamp_ms),
        .o_rate_hz         (o_rate_hz),
        .o_blocks_in_frame (o_blocks_in_frame),
        .o_timed           (o_timed),
        .o_flushed_tail    (o_flushed_tail)
    );

endmodule

### tb/adts_deframer_timestamper_checker.sv
module adts_deframer_timestamper_checker import adts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    input  logic        o_empty,
    input  logic        i_pop,
    input  logic [15:0] o_frame_bytes,
    input  logic [47:0] o_stamp_ticks,
    input  logic [41:0] o_stamp_ms,
    input  logic [16:0] o_rate_hz,
    input  logic [2:0]  o_blocks_in_frame,
    input  logic        o_timed,
    input  logic        o_flushed_tail,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [46:0] i_cfg_data,
    output int          fail_count,
    output int          frames_pending,
    output int          frames_checked
);

    typedef struct packed {
        logic [15:0] len;
        logic [47:0] ticks;
        logic [41:0] ms;
        logic [16:0] rate;
        logic [2:0]  blocks;
        logic        timed;
        logic        tail;
    } t_frame_desc;

    localparam int unsigned OFFSET_MAX = 65535;
    localparam logic [16:0] RATES [16] = '{
        17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
        17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
        17'd0, 17'd0, 17'd0, 17'd0
    };

    t_frame_desc  desc_q[$];
    logic [15:0]  window;
    bit           hunting;
    int unsigned  offset;
    logic [12:0]  hdr_len;
    logic [3:0]   hdr_idx;
    logic [1:0]   hdr_bits;
    logic [31:0]  frames_at_rate;
    logic [2:0]   blocks;
    logic [16:0]  rate;
    logic [47:0]  base_ticks;
    logic [31:0]  offset_ticks;

    function automatic logic [63:0] elapsed_ticks();
        if (rate == 0) return 64'd0;
        return (64'(frames_at_rate) * 64'd92160000) / 64'(rate);
    endfunction

    task automatic clear_frame();
        offset = 0;
        hdr_len = '0;
        hdr_idx = '0;
        hdr_bits = '0;
    endtask

    task automatic open_frame();
        hunting = 0;
        offset = 2;
        hdr_len = '0;
        hdr_idx = '0;
        hdr_bits = '0;
    endtask

    task automatic apply_header();
        logic [16:0] r;
        r = RATES[hdr_idx];
        if (r != 0) begin
            blocks = 3'(hdr_bits) + 3'd1;
            if (r != rate) begin
                base_ticks = base_ticks + elapsed_ticks();
                frames_at_rate = '0;
                rate = r;
            end
        end
    endtask

    task automatic stamp_frame(int unsigned len, bit tail);
        t_frame_desc d;
        longint signed s;
        d.timed = (rate != 0);
        if (d.timed) begin
            d.ticks = base_ticks + {{16{offset_ticks[31]}}, offset_ticks}
                      + elapsed_ticks();
        end else begin
            d.ticks = base_ticks;
        end
        s = {{16{d.ticks[47]}}, d.ticks};
        s = s / 90;
        d.ms = s[41:0];
        d.len = (len > OFFSET_MAX) ? 16'hffff : len[15:0];
        d.rate = rate;
        d.blocks = blocks;
        d.tail = tail;
        desc_q.push_back(d);
        frames_at_rate = frames_at_rate + 32'(blocks);
    endtask

    task automatic step(logic [7:0] b, logic last);
        bit sync;
        window = {window[7:0], b};
        sync = (window & 16'hfff6) == 16'hfff0;
        if (hunting) begin
            if (sync) open_frame();
        end else begin
            if (!last && sync && offset >= 8 && hdr_len <= offset - 1) begin
                apply_header();
                stamp_frame(offset - 1, 0);
                open_frame();
                return;
            end
            case (offset)
                2: hdr_idx = b[5:2];
                3: hdr_len = {b[1:0], 11'd0};
                4: hdr_len = hdr_len | {2'd0, b, 3'd0};
                5: hdr_len = hdr_len | {10'd0, b[7:5]};
                6: hdr_bits = b[1:0];
                default: ;
            endcase
            if (offset < OFFSET_MAX) offset++;
        end
        if (last) begin
            if (!hunting) stamp_frame(offset, 1);
            hunting = 1;
            window = '0;
            clear_frame();
        end
    endtask

    task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name,
                 exp_v, act_v);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_desc d;
        if (!i_rst_n) begin
            desc_q.delete();
            fail_count = 0;
            frames_checked = 0;
            frames_pending = 0;
            window = '0;
            hunting = 1;
            clear_frame();
            frames_at_rate = '0;
            blocks = 3'd1;
            rate = '0;
            base_ticks = '0;
            offset_ticks = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_START_TIME) begin
                    base_ticks = {1'b0, i_cfg_data};
                    frames_at_rate = '0;
                end else begin
                    offset_ticks = i_cfg_data[31:0];
                end
            end
            if (!o_empty && i_pop) begin
                if (desc_q.size() == 0) begin
                    $display("%0t: frame descriptor with none expected", $realtime);
                    fail_count++;
                end else begin
                    d = desc_q.pop_front();
                    frames_checked++;
                    if (d.len != o_frame_bytes) report("frame_bytes", d.len, o_frame_bytes);
                    if (d.ticks != o_stamp_ticks)
                        report("stamp_ticks", d.ticks, o_stamp_ticks);
                    if (d.ms != o_stamp_ms) report("stamp_ms", d.ms, o_stamp_ms);
                    if (d.rate != o_rate_hz) report("rate_hz", d.rate, o_rate_hz);
                    if (d.blocks != o_blocks_in_frame)
                        report("blocks_in_frame", d.blocks, o_blocks_in_frame);
                    if (d.timed != o_timed) report("timed", d.timed, o_timed);
                    if (d.tail != o_flushed_tail)
                        report("flushed_tail", d.tail, o_flushed_tail);
                end
            end
            if (i_push && !o_full) step(i_data_byte, i_stream_end);
            frames_pending = desc_q.size();
        end
    end

endmodule

### tb/adts_deframer_timestamper_tb.sv
module adts_deframer_timestamper_tb;
    import adts_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [7:0]  i_data_byte = '0;
    logic        i_stream_end = 1'b0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [15:0] o_frame_bytes;
    logic [47:0] o_stamp_ticks;
    logic [41:0] o_stamp_ms;
    logic [16:0] o_rate_hz;
    logic [2:0]  o_blocks_in_frame;
    logic        o_timed;
    logic        o_flushed_tail;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_START_TIME;
    logic [46:0] i_cfg_data = '0;

    int fail_count;
    int frames_pending;
    int frames_checked;
    int bytes_sent = 0;
    int settings_used = 0;
    int idle_pct = 76;
    bit tx_idle_on = 0;
    bit rx_stall_on = 0;
    bit hold_req = 0;

    adts_deframer_timestamper uut (.*);
    adts_deframer_timestamper_checker chk (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_pop <= 1'b0;
                repeat (2000) @(posedge i_clk);
                hold_req = 0;
            end else begin
                i_pop <= !(rx_stall_on && $urandom_range(0, 99) < idle_pct);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n) begin
                idle = 0;
            end else if (++idle >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $realtime, idle);
                $display("[adts_deframer_timestamper] ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last = 1'b0);
        while (tx_idle_on && $urandom_range(0, 99) < idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_data_byte <= b;
        i_stream_end <= last;
        do @(posedge i_clk); while (o_full);
        bytes_sent++;
    endtask

    task automatic send_frame(int decl_len, int real_len, logic [3:0] idx, logic [1:0] bits,
                              int end_at = -1);
        logic [7:0] hdr [7];
        logic [7:0] r;
        logic [12:0] len13;
        len13 = decl_len[12:0];
        r = $urandom;
        hdr[0] = 8'hff;
        hdr[1] = {4'hf, r[0], 2'b00, r[1]};
        hdr[2] = {r[7:6], idx, r[3:2]};
        r = $urandom;
        hdr[3] = {r[7:2], len13[12:11]};
        hdr[4] = len13[10:3];
        hdr[5] = {len13[2:0], r[4:0]};
        r = $urandom;
        hdr[6] = {r[7:2], bits};
        for (int i = 0; i < real_len; i++) begin
            send_byte(i < 7 ? hdr[i] : 8'($urandom), i == end_at);
            if (i == end_at) return;
        end
    endtask

    task automatic settle();
        i_push <= 1'b0;
        do @(posedge i_clk); while (frames_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [46:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(logic [46:0] start_ticks, logic [31:0] offs);
        settle();
        cfg_write(CFG_START_TIME, start_ticks);
        cfg_write(CFG_TIME_OFFSET, {15'd0, offs});
        settings_used++;
    endtask

    task automatic random_phase(int byte_budget);
        int stop_at, len, pick;
        logic [3:0] idx;
        stop_at = bytes_sent + byte_budget;
        idx = 4'($urandom_range(0, 11));
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            len = $urandom_range(7, 20);
            if ($urandom_range(0, 99) < 30) idx = 4'($urandom);
            if (pick < 80) begin
                send_frame(len, len, idx, 2'($urandom));
            end else if (pick < 87) begin
                send_frame($urandom_range(0, 40), len, idx, 2'($urandom));
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                send_frame(len, len, idx, 2'($urandom), $urandom_range(0, len - 1));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_timing(47'd0, 32'd0);
        send_byte(8'h12);
        send_byte(8'h34, 1'b1);
        send_byte(8'hff);
        send_byte(8'hf9, 1'b1);
        send_frame(9, 9, 4'd12, 2'd3);
        send_frame(0, 8, 4'd15, 2'd0);
        for (int i = 0; i < 16; i++) begin
            send_frame(7 + i, 7 + i, 4'(i), 2'(i));
        end
        send_frame(20, 10, 4'd3, 2'd1);
        send_frame(10, 10, 4'd3, 2'd2, 5);
        send_frame(8, 8, 4'd4, 2'd0);
        send_frame(8, 8, 4'd4, 2'd0, 7);

        set_timing(47'h7fff_ffff_ffff, 32'h7fff_ffff);
        send_frame(8191, 7, 4'd0, 2'd3);
        for (int i = 7; i < 150; i++) begin
            if (i % 50 == 0) begin
                send_byte(8'hff);
                send_byte(8'hf0);
                i++;
            end else begin
                send_byte(8'($urandom_range(0, 254)));
            end
        end
        send_byte(8'h00, 1'b1);
        send_frame(8, 8, 4'd1, 2'd1);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    tx_idle_on = 0;
                    rx_stall_on = 0;
                    idle_pct = 76;
                end
                1: begin
                    tx_idle_on = 1;
                    rx_stall_on = 0;
                    idle_pct = 76;
                end
                2: begin
                    tx_idle_on = 0;
                    rx_stall_on = 1;
                    idle_pct = 76;
                end
                default: begin
                    tx_idle_on = 1;
                    rx_stall_on = 1;
                    idle_pct = 26;
                end
            endcase
            case (ph)
                0: set_timing(47'd0, 32'h8000_0000);
                1: set_timing(47'h7fff_ffff_ffff, 32'h8000_0000);
                2: set_timing(47'd0, 32'h7fff_ffff);
                default: set_timing(47'({$urandom, $urandom}), $urandom);
            endcase
            if (ph == 0) hold_req = 1;
            random_phase(ph == 0 ? 150 : 45);
        end

        settle();
        $display("Sent %0d stream bytes under %0d timing settings and four idling patterns.",
                 bytes_sent, settings_used);
        $display("Checked %0d frame descriptors, including flushed tails and bad rate indexes.",
                 frames_checked);
        if (fail_count == 0) begin
            $display("[adts_deframer_timestamper] OK");
        end else begin
            $display("[adts_deframer_timestamper] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/adts_pkg.sv
hw/rtl/adts_front.sv
hw/rtl/adts_evq.sv
hw/rtl/adts_div.sv
hw/rtl/adts_back.sv
hw/rtl/adts_deframer_timestamper.sv
tb/adts_deframer_timestamper_checker.sv
tb/adts_deframer_timestamper_tb.sv
